// File: sv/fbq_pkg.sv
// shared types and constants for the fault burst quarantine block
package fbq_pkg;

	localparam int unsigned TID_W   = 6;
	localparam int unsigned PC_W    = 64;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned TICK_IN_W = 32;
	localparam int unsigned BURST_W = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		ACT_SKIP    = 3'd0,
		ACT_RESUME  = 3'd1,
		ACT_QUAR    = 3'd2,
		ACT_PANIC   = 3'd3,
		ACT_PARK    = 3'd4,
		ACT_HALTED  = 3'd5,
		ACT_CLEARED = 3'd6
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_TICKS    = 2'd0,
		CFG_BURST_THRESHOLD = 2'd1,
		CFG_DETECTOR_ENABLE = 2'd2
	} cfg_index_t;

	typedef enum logic {
		KIND_FAULT = 1'b0,
		KIND_CLEAR = 1'b1
	} kind_t;

endpackage

// File: sv/fault_burst_quarantine.sv
// top level of the per-task fault burst watchdog
// One word in, one word out. A fault word reads its task slot from the slot table, works out
// the burst window, count and quarantine decision in one pass and writes the slot back, so a
// new word can be taken every cycle unless in_stall holds it (during the reset sweep, or
// while a stalled result fills both registers): the slot table has one write and one read
// port, and a word that follows one for the same slot sees the fresh entry through a bypass
// on the read register. An accepted word moves from the stage 1 word register to the result
// register, where it is held until it is taken. After reset the slot table is swept to zero,
// one slot per cycle; in_stall is held high meanwhile, configuration writes are taken as
// ever. Once a kernel panic or a cpu park has been reported the block is halted: every later
// word answers "halted" with the pc unchanged until the next reset. task_id is folded onto
// the slots modulo TASK_SLOTS.
module fault_burst_quarantine #(
	parameter int unsigned TASK_SLOTS = 64,
	parameter int unsigned TICK_BITS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,

	// configuration write port
	input  logic                               cfg_wr_en,
	input  logic [fbq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fbq_pkg::CFG_DATA_W-1:0]     cfg_data,

	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               kind,
	input  logic [fbq_pkg::TID_W-1:0]          task_id,
	input  logic                               task_present,
	input  logic                               user_mode,
	input  logic                               locks_held,
	input  logic [fbq_pkg::TICK_IN_W-1:0]      now_tick,
	input  logic [fbq_pkg::PC_W-1:0]           fault_pc,
	input  logic [fbq_pkg::LEN_W-1:0]          instr_length,

	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         action,
	output logic [fbq_pkg::PC_W-1:0]           next_pc,
	output logic                               enqueue_valid,
	output logic [fbq_pkg::TID_W-1:0]          enqueue_task,
	output logic [fbq_pkg::BURST_W-1:0]        burst_count
);

	localparam int unsigned SLOT_W  = $clog2(TASK_SLOTS);
	localparam int unsigned ENT_W   = TICK_BITS + fbq_pkg::BURST_W + 1;
	localparam int unsigned CMP_W   = (TICK_BITS > fbq_pkg::TICK_IN_W) ?
		TICK_BITS : fbq_pkg::TICK_IN_W;
	localparam int unsigned TID_NUM = 2 ** fbq_pkg::TID_W;
	localparam logic [fbq_pkg::BURST_W-1:0] BURST_MAX = '1;

	// configuration registers
	logic [fbq_pkg::TICK_IN_W-1:0] window_ticks_q;
	logic [fbq_pkg::BURST_W-1:0]   burst_threshold_q;
	logic                          detector_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ticks_q    <= 32'd100;
			burst_threshold_q <= 16'd10;
			detector_enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fbq_pkg::CFG_WINDOW_TICKS:
					window_ticks_q <= cfg_data;
				fbq_pkg::CFG_BURST_THRESHOLD:
					burst_threshold_q <= cfg_data[fbq_pkg::BURST_W-1:0];
				fbq_pkg::CFG_DETECTOR_ENABLE:
					detector_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// task id to slot, a constant table worked out at elaboration
	logic [SLOT_W-1:0] slot_lut [TID_NUM];
	for (genvar g = 0; g < TID_NUM; g++) begin : g_slot_lut
		assign slot_lut[g] = SLOT_W'(g % TASK_SLOTS);
	end

	logic [SLOT_W-1:0] in_slot;
	assign in_slot = slot_lut[task_id];

	// handshake control
	logic clr_busy_q;
	logic s1_valid_q;
	logic out_valid_q;
	logic out_free;
	logic s1_adv;
	logic in_acc;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = s1_valid_q && out_free;
	// once the reset sweep is done, stage 1 may take a new word when it is empty or passing its word on this edge
	assign in_stall = clr_busy_q || (s1_valid_q && !out_free);
	assign in_acc   = in_valid && !in_stall;

	// reset sweep of the slot table
	logic [SLOT_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == SLOT_W'(TASK_SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// stage 1 word register
	logic                        kind_s1;
	logic [fbq_pkg::TID_W-1:0]   task_id_s1;
	logic [SLOT_W-1:0]           slot_s1;
	logic                        present_s1;
	logic                        user_s1;
	logic                        locks_s1;
	logic [fbq_pkg::TICK_IN_W-1:0] now_s1;
	logic [fbq_pkg::PC_W-1:0]    pc_s1;
	logic [fbq_pkg::LEN_W-1:0]   len_s1;
	logic [ENT_W-1:0]            ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1    <= kind;
			task_id_s1 <= task_id;
			slot_s1    <= in_slot;
			present_s1 <= task_present;
			user_s1    <= user_mode;
			locks_s1   <= locks_held;
			now_s1     <= now_tick;
			pc_s1      <= fault_pc;
			len_s1     <= instr_length;
		end
	end

	// slot table: {quarantined, burst count, window start}
	logic [ENT_W-1:0]  slot_mem_q [TASK_SLOTS];
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [ENT_W-1:0]  mem_wdata;
	logic              upd_we;
	logic [ENT_W-1:0]  upd_data;

	assign mem_we    = clr_busy_q || (s1_adv && upd_we);
	assign mem_waddr = clr_busy_q ? clr_addr_q : slot_s1;
	assign mem_wdata = clr_busy_q ? '0 : upd_data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_waddr] <= mem_wdata;
		end
	end

	// read register, bypassed when the word ahead writes the same slot on this edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (mem_we && (mem_waddr == in_slot)) begin
				ent_s1 <= mem_wdata;
			end else begin
				ent_s1 <= slot_mem_q[in_slot];
			end
		end
	end

	// decision logic
	logic                        cur_quar;
	logic [fbq_pkg::BURST_W-1:0] cur_cnt;
	logic [TICK_BITS-1:0]        cur_ws;
	logic [TICK_BITS-1:0]        tick_now;
	logic [TICK_BITS-1:0]        tick_diff;
	logic                        in_window;
	logic [fbq_pkg::BURST_W-1:0] new_cnt;
	logic [TICK_BITS-1:0]        new_ws;
	logic [fbq_pkg::PC_W-1:0]    adv_pc;
	logic                        halted_q;
	logic                        halt_set;
	fbq_pkg::action_t            act_d;
	logic [fbq_pkg::PC_W-1:0]    npc_d;
	logic                        enq_d;
	logic [fbq_pkg::TID_W-1:0]   etask_d;
	logic [fbq_pkg::BURST_W-1:0] cnt_d;

	assign cur_quar = ent_s1[ENT_W-1];
	assign cur_cnt  = ent_s1[TICK_BITS +: fbq_pkg::BURST_W];
	assign cur_ws   = ent_s1[TICK_BITS-1:0];

	// tick difference wraps at the stored tick width
	assign tick_now  = TICK_BITS'(CMP_W'(now_s1));
	assign tick_diff = tick_now - cur_ws;
	assign in_window = CMP_W'(tick_diff) <= CMP_W'(window_ticks_q);
	assign adv_pc    = pc_s1 + fbq_pkg::PC_W'(len_s1);

	always_comb begin
		new_cnt = 16'd1;
		new_ws  = tick_now;
		if (in_window) begin
			new_ws  = cur_ws;
			new_cnt = (cur_cnt == BURST_MAX) ? cur_cnt : cur_cnt + 1'b1;
		end
	end

	always_comb begin
		act_d    = fbq_pkg::ACT_RESUME;
		npc_d    = adv_pc;
		enq_d    = 1'b0;
		etask_d  = '0;
		cnt_d    = cur_cnt;
		upd_we   = 1'b0;
		upd_data = ent_s1;
		halt_set = 1'b0;
		if (halted_q) begin
			act_d = fbq_pkg::ACT_HALTED;
			npc_d = pc_s1;
		end else if (kind_s1 == fbq_pkg::KIND_CLEAR) begin
			// slot handed back to a fresh task
			act_d    = fbq_pkg::ACT_CLEARED;
			npc_d    = '0;
			cnt_d    = '0;
			upd_we   = 1'b1;
			upd_data = '0;
		end else if (present_s1 && cur_quar) begin
			act_d = fbq_pkg::ACT_SKIP;
			npc_d = pc_s1;
		end else if (!present_s1 || !user_s1) begin
			// kernel fault or no current task
			act_d    = fbq_pkg::ACT_PANIC;
			npc_d    = pc_s1;
			cnt_d    = present_s1 ? cur_cnt : '0;
			halt_set = 1'b1;
		end else if (!detector_enable_q) begin
			act_d = fbq_pkg::ACT_RESUME;
		end else begin
			upd_we   = 1'b1;
			upd_data = {cur_quar, new_cnt, new_ws};
			cnt_d    = new_cnt;
			if (new_cnt >= burst_threshold_q) begin
				if (locks_s1) begin
					// lock held, so the task cannot be torn down: park the cpu
					act_d    = fbq_pkg::ACT_PARK;
					npc_d    = pc_s1;
					halt_set = 1'b1;
				end else begin
					act_d    = fbq_pkg::ACT_QUAR;
					enq_d    = 1'b1;
					etask_d  = task_id_s1;
					upd_data = {1'b1, new_cnt, new_ws};
				end
			end
		end
	end

	// sticky halt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (s1_adv && halt_set) begin
			halted_q <= 1'b1;
		end
	end

	// result register
	logic [2:0]                  action_q;
	logic [fbq_pkg::PC_W-1:0]    next_pc_q;
	logic                        enqueue_valid_q;
	logic [fbq_pkg::TID_W-1:0]   enqueue_task_q;
	logic [fbq_pkg::BURST_W-1:0] burst_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			action_q        <= act_d;
			next_pc_q       <= npc_d;
			enqueue_valid_q <= enq_d;
			enqueue_task_q  <= etask_d;
			burst_count_q   <= cnt_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign next_pc       = next_pc_q;
	assign enqueue_valid = enqueue_valid_q;
	assign enqueue_task  = enqueue_task_q;
	assign burst_count   = burst_count_q;

	// checks
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag dropped");

	a_halt_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && halt_set) |=> (halted_q && out_valid_q &&
		((action_q == fbq_pkg::ACT_PANIC) || (action_q == fbq_pkg::ACT_PARK))))
		else $error("panic or park not followed by halt");

	a_enq_quar: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (enqueue_valid_q == (action_q == fbq_pkg::ACT_QUAR)))
		else $error("enqueue request without quarantine");

	a_no_word_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!s1_valid_q && !out_valid_q))
		else $error("word in flight during table sweep");

endmodule
